// ===== hdl/mced_pkg.sv =====
// Shared types and constants for the mouse click event detector.
// Used by mced_cfg, mced_eval and mouse_click_event_detector; depends on nothing.

package mced_pkg;

    // Event codes reported with each item on the result channel.
    typedef enum logic [2:0] {
        EVK_RELEASED = 3'd0,
        EVK_MOVED    = 3'd1,
        EVK_RIGHT    = 3'd2,
        EVK_LEFT     = 3'd3,
        EVK_DOUBLE   = 3'd4
    } t_evk;

    // Configuration register indexes (byte address is four times the index).
    typedef enum logic [1:0] {
        REG_DOUBLE_WINDOW = 2'd0,
        REG_FIRST_REPEAT  = 2'd1,
        REG_NEXT_REPEAT   = 2'd2
    } t_reg_idx;

    localparam int unsigned MAX_EVENTS = 4;
    localparam int unsigned TICK_W     = 32;
    localparam int unsigned DELAY_W    = 16;
    localparam int unsigned POS_W      = 8;
    localparam int unsigned CNT_W      = 3;
    localparam int unsigned PADDR_W    = 4;
    localparam int unsigned PDATA_W    = 32;

    localparam logic [DELAY_W-1:0] DOUBLE_WINDOW_RST = 16'd5;
    localparam logic [DELAY_W-1:0] FIRST_REPEAT_RST  = 16'd7;
    localparam logic [DELAY_W-1:0] NEXT_REPEAT_RST   = 16'd1;

    // One poll of the mouse.
    typedef struct packed {
        logic [TICK_W-1:0] tick_now;
        logic [POS_W-1:0]  pos_x;
        logic [POS_W-1:0]  pos_y;
        logic              released;
        logic              left_down;
        logic              right_down;
    } t_in_item;

    // One mouse event.
    typedef struct packed {
        logic [2:0]       event_kind;
        logic [POS_W-1:0] event_x;
        logic [POS_W-1:0] event_y;
        logic             last_event;
    } t_out_item;

    // Event held in the result buffer, before the last flag is attached.
    typedef struct packed {
        t_evk             kind;
        logic [POS_W-1:0] x;
        logic [POS_W-1:0] y;
    } t_evt;

    // All events that one poll produces, packed from slot 0 upward.
    typedef struct packed {
        logic [CNT_W-1:0]           count;
        t_evt [MAX_EVENTS-1:0]      ev;
    } t_evt_set;

    // Timing registers.
    typedef struct packed {
        logic [DELAY_W-1:0] double_window;
        logic [DELAY_W-1:0] first_repeat;
        logic [DELAY_W-1:0] next_repeat;
    } t_cfg;

    function automatic t_evt mk_evt(t_evk kind, logic [POS_W-1:0] x, logic [POS_W-1:0] y);
        t_evt e;
        e.kind = kind;
        e.x    = x;
        e.y    = y;
        return e;
    endfunction

endpackage

// ===== hdl/mced_cfg.sv =====
// APB register file holding the three timing registers of the detector.
// Depends on mced_pkg for the register indexes, widths and reset values.

module mced_cfg (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [mced_pkg::PADDR_W-1:0]      paddr,
    input  logic [mced_pkg::PDATA_W-1:0]      pwdata,
    output logic [mced_pkg::PDATA_W-1:0]      prdata,
    output logic                              pready,
    output mced_pkg::t_cfg                    o_cfg
);

    mced_pkg::t_cfg r_cfg;
    logic           wr_en;
    logic [1:0]     reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[3:2];

    // Register writes; an address past the last register is ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.double_window <= mced_pkg::DOUBLE_WINDOW_RST;
            r_cfg.first_repeat  <= mced_pkg::FIRST_REPEAT_RST;
            r_cfg.next_repeat   <= mced_pkg::NEXT_REPEAT_RST;
        end else if (wr_en) begin
            case (reg_idx)
                mced_pkg::REG_DOUBLE_WINDOW: begin
                    r_cfg.double_window <= pwdata[mced_pkg::DELAY_W-1:0];
                end
                mced_pkg::REG_FIRST_REPEAT: begin
                    r_cfg.first_repeat <= pwdata[mced_pkg::DELAY_W-1:0];
                end
                mced_pkg::REG_NEXT_REPEAT: begin
                    r_cfg.next_repeat <= pwdata[mced_pkg::DELAY_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // Read data, zero extended.
    always_comb begin
        case (reg_idx)
            mced_pkg::REG_DOUBLE_WINDOW: begin
                prdata = mced_pkg::PDATA_W'(r_cfg.double_window);
            end
            mced_pkg::REG_FIRST_REPEAT: begin
                prdata = mced_pkg::PDATA_W'(r_cfg.first_repeat);
            end
            mced_pkg::REG_NEXT_REPEAT: begin
                prdata = mced_pkg::PDATA_W'(r_cfg.next_repeat);
            end
            default: begin
                prdata = '0;
            end
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

// ===== hdl/mced_eval.sv =====
// Poll evaluator: holds position, press and timer state and turns one poll
// into up to four events. Depends on mced_pkg for item, event and config types.

module mced_eval (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_load,
    input  mced_pkg::t_in_item   i_item,
    input  mced_pkg::t_cfg       i_cfg,
    output mced_pkg::t_evt_set   o_set
);

    // Position and press state.
    logic [mced_pkg::POS_W-1:0]   r_cur_x, n_cur_x;
    logic [mced_pkg::POS_W-1:0]   r_cur_y, n_cur_y;
    logic                         r_seen, n_seen;
    logic [mced_pkg::POS_W-1:0]   r_press_x, n_press_x;
    logic [mced_pkg::POS_W-1:0]   r_press_y, n_press_y;
    logic                         r_press_vld, n_press_vld;

    // Double-click timer (0) and repeat-delay timer (1). An elapsed timer
    // behaves like a stopped one, so one running bit covers both.
    logic                         r_t0_on, n_t0_on;
    logic [mced_pkg::TICK_W-1:0]  r_t0_start, n_t0_start;
    logic [mced_pkg::TICK_W-1:0]  r_t0_end, n_t0_end;
    logic                         r_t1_on, n_t1_on;
    logic [mced_pkg::TICK_W-1:0]  r_t1_start, n_t1_start;
    logic [mced_pkg::TICK_W-1:0]  r_t1_end, n_t1_end;
    logic [mced_pkg::DELAY_W-1:0] r_rep_wait, n_rep_wait;

    mced_pkg::t_evt_set           evs;

    // Evaluate one poll in event order: release, move, right, left.
    always_comb begin
        logic [mced_pkg::TICK_W-1:0] now;
        logic [mced_pkg::CNT_W-1:0]  k;
        logic                        same;
        logic                        t0_gone;
        logic                        t1_gone;

        now = i_item.tick_now;
        k   = '0;

        n_cur_x     = r_cur_x;
        n_cur_y     = r_cur_y;
        n_seen      = r_seen;
        n_press_x   = r_press_x;
        n_press_y   = r_press_y;
        n_press_vld = r_press_vld;
        n_t0_on     = r_t0_on;
        n_t0_start  = r_t0_start;
        n_t0_end    = r_t0_end;
        n_t1_on     = r_t1_on;
        n_t1_start  = r_t1_start;
        n_t1_end    = r_t1_end;
        n_rep_wait  = r_rep_wait;
        evs         = '0;

        // Release: report the old position and open the double-click window.
        if (i_item.released) begin
            n_t0_on    = 1'b1;
            n_t0_start = now;
            n_t0_end   = now + mced_pkg::TICK_W'(i_cfg.double_window);
            n_t1_on    = 1'b0;
            evs.ev[k[1:0]] = mced_pkg::mk_evt(mced_pkg::EVK_RELEASED, r_cur_x, r_cur_y);
            k = k + 1'b1;
        end

        // Move: any change of cell, or the very first poll.
        if (!r_seen || i_item.pos_x != r_cur_x || i_item.pos_y != r_cur_y) begin
            n_cur_x = i_item.pos_x;
            n_cur_y = i_item.pos_y;
            n_seen  = 1'b1;
            evs.ev[k[1:0]] = mced_pkg::mk_evt(mced_pkg::EVK_MOVED, i_item.pos_x,
                                              i_item.pos_y);
            k = k + 1'b1;
        end

        // Right button held.
        if (i_item.right_down) begin
            evs.ev[k[1:0]] = mced_pkg::mk_evt(mced_pkg::EVK_RIGHT, i_item.pos_x,
                                              i_item.pos_y);
            k = k + 1'b1;
        end

        // Left button: double click, auto-repeat, or a new press.
        same    = r_press_vld && i_item.pos_x == r_press_x && i_item.pos_y == r_press_y;
        t0_gone = (now < n_t0_start) || (now >= n_t0_end);
        t1_gone = (now < r_t1_start) || (now >= r_t1_end);
        if (i_item.left_down) begin
            if (same) begin
                if (n_t0_on && !t0_gone) begin
                    n_t0_on = 1'b0;
                    evs.ev[k[1:0]] = mced_pkg::mk_evt(mced_pkg::EVK_DOUBLE, i_item.pos_x,
                                                      i_item.pos_y);
                    k = k + 1'b1;
                end else begin
                    // Any double-click window has run out or was never opened.
                    n_t0_on = 1'b0;
                    if (!(n_t1_on && !t1_gone)) begin
                        n_t1_on    = 1'b1;
                        n_t1_start = now;
                        n_t1_end   = now + mced_pkg::TICK_W'(r_rep_wait);
                        n_rep_wait = i_cfg.next_repeat;
                        evs.ev[k[1:0]] = mced_pkg::mk_evt(mced_pkg::EVK_LEFT, i_item.pos_x,
                                                          i_item.pos_y);
                        k = k + 1'b1;
                    end
                end
            end else begin
                n_t0_on     = 1'b0;
                n_t1_on     = 1'b1;
                n_t1_start  = now;
                n_t1_end    = now + mced_pkg::TICK_W'(i_cfg.first_repeat);
                n_rep_wait  = i_cfg.next_repeat;
                n_press_x   = i_item.pos_x;
                n_press_y   = i_item.pos_y;
                n_press_vld = 1'b1;
                evs.ev[k[1:0]] = mced_pkg::mk_evt(mced_pkg::EVK_LEFT, i_item.pos_x,
                                                  i_item.pos_y);
                k = k + 1'b1;
            end
        end else begin
            n_rep_wait = i_cfg.first_repeat;
        end

        evs.count = k;
    end

    // Control state, updated only when a poll is evaluated.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen      <= 1'b0;
            r_press_vld <= 1'b0;
            r_t0_on     <= 1'b0;
            r_t1_on     <= 1'b0;
            r_rep_wait  <= mced_pkg::FIRST_REPEAT_RST;
            r_cur_x     <= '0;
            r_cur_y     <= '0;
            r_press_x   <= '0;
            r_press_y   <= '0;
        end else if (i_load) begin
            r_seen      <= n_seen;
            r_press_vld <= n_press_vld;
            r_t0_on     <= n_t0_on;
            r_t1_on     <= n_t1_on;
            r_rep_wait  <= n_rep_wait;
            r_cur_x     <= n_cur_x;
            r_cur_y     <= n_cur_y;
            r_press_x   <= n_press_x;
            r_press_y   <= n_press_y;
        end
    end

    // Timer bounds only matter while the matching timer runs.
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_t0_start <= n_t0_start;
            r_t0_end   <= n_t0_end;
            r_t1_start <= n_t1_start;
            r_t1_end   <= n_t1_end;
        end
    end

    assign o_set = evs;

endmodule

// ===== hdl/mouse_click_event_detector.sv =====
// Top level of the mouse click event detector: input register, result buffer,
// APB register file and poll evaluator. Depends on mced_pkg, mced_cfg, mced_eval.

// Each accepted poll lands in an input register and is evaluated as soon
// as the result buffer is empty or hands over its last event. A poll yields
// zero to four events, which leave the result buffer one per cycle while
// the output is not stalled. The first event passes through the input
// register and the result buffer before it reaches the output. The input
// register takes the next poll while events of the previous one are still
// being delivered. Timing registers are to be written over APB only while
// the block is idle; the block itself does not enforce this. Double-click
// window is at 0x0, first repeat delay at 0x4, later repeat delay at 0x8,
// each 16 bits in the low half.

module mouse_click_event_detector (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Poll channel
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  mced_pkg::t_in_item                i_in_data,
    // Event channel
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output mced_pkg::t_out_item               o_out_data,
    // Register port
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [mced_pkg::PADDR_W-1:0]      paddr,
    input  logic [mced_pkg::PDATA_W-1:0]      pwdata,
    output logic [mced_pkg::PDATA_W-1:0]      prdata,
    output logic                              pready
);

    mced_pkg::t_cfg                             cfg;
    mced_pkg::t_evt_set                         evs;

    logic                                       r_in_valid;
    mced_pkg::t_in_item                         r_in;
    mced_pkg::t_evt [mced_pkg::MAX_EVENTS-1:0]  r_ev;
    logic [mced_pkg::CNT_W-1:0]                 r_left;

    logic in_take;
    logic out_take;
    logic buf_free;
    logic load;

    mced_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    mced_eval u_eval (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (load),
        .i_item  (r_in),
        .i_cfg   (cfg),
        .o_set   (evs)
    );

    // Handshakes: the buffer takes a new poll once it is drained or draining.
    assign out_take   = o_out_valid && !i_out_stall;
    assign buf_free   = (r_left == '0) || (r_left == mced_pkg::CNT_W'(1) && out_take);
    assign load       = r_in_valid && buf_free;
    assign o_in_stall = r_in_valid && !load;
    assign in_take    = i_in_valid && !o_in_stall;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (load) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in <= i_in_data;
        end
    end

    // Result buffer count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left <= '0;
        end else if (load) begin
            r_left <= evs.count;
        end else if (out_take) begin
            r_left <= r_left - 1'b1;
        end
    end

    // Result buffer contents; events shift toward slot 0 as they leave.
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_ev <= evs.ev;
        end else if (out_take) begin
            for (int i = 0; i < mced_pkg::MAX_EVENTS - 1; i++) begin
                r_ev[i] <= r_ev[i+1];
            end
        end
    end

    // Event channel outputs.
    assign o_out_valid           = (r_left != '0);
    assign o_out_data.event_kind = r_ev[0].kind;
    assign o_out_data.event_x    = r_ev[0].x;
    assign o_out_data.event_y    = r_ev[0].y;
    assign o_out_data.last_event = (r_left == mced_pkg::CNT_W'(1));

    // The buffer never holds more events than one poll can produce.
    a_left_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_left <= mced_pkg::CNT_W'(mced_pkg::MAX_EVENTS))
        else $error("result buffer count out of range");

    // A poll is only evaluated into an empty or draining buffer.
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load |-> (r_left == '0 || (r_left == mced_pkg::CNT_W'(1) && out_take)))
        else $error("poll evaluated over pending events");

    // After the last event of a poll leaves with nothing new loaded, output goes idle.
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_take && o_out_data.last_event && !load) |=> !o_out_valid)
        else $error("event delivered after the last event of a poll");

    // Input stall only while a poll waits in the input register.
    a_stall_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> r_in_valid)
        else $error("input stalled with empty input register");

endmodule
